[hdl/cvpp_pkg.sv]
// ----------------------------------------------------------------------------
// cvpp_pkg
// Shared types and constants of the camera view and pinhole projection block.
// ----------------------------------------------------------------------------
package cvpp_pkg;

   localparam int COORD_WIDTH_DEFAULT = 16;
   localparam int CSR_INDEX_WIDTH     = 3;
   localparam int CSR_DATA_WIDTH      = 48;
   localparam int OUT_WIDTH           = 32;
   localparam int QUO_WIDTH           = 33;
   localparam int DIV_STAGES          = 33;

   localparam logic [CSR_INDEX_WIDTH-1:0] REG_BASIS_RIGHT   = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_BASIS_UP      = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_BASIS_FORWARD = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_CAMERA_POS    = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_FOCAL_LENGTH  = 3'd4;

   localparam logic [47:0] RESET_BASIS_RIGHT   = 48'h0000_0000_4000;
   localparam logic [47:0] RESET_BASIS_UP      = 48'h0000_4000_0000;
   localparam logic [47:0] RESET_BASIS_FORWARD = 48'h4000_0000_0000;
   localparam logic [47:0] RESET_CAMERA_POS    = 48'h0000_0000_0000;
   localparam logic [15:0] RESET_FOCAL_LENGTH  = 16'h0100;

   typedef struct packed {
      logic [47:0] basis_right;
      logic [47:0] basis_up;
      logic [47:0] basis_forward;
      logic [47:0] camera_position;
      logic [15:0] focal_length;
   } cfg_type;

   // One projection lane of the divider: dividend low bits, partial
   // remainder, quotient built so far, quotient sign and overflow.
   typedef struct packed {
      logic [QUO_WIDTH-1:0] nlo;
      logic [31:0]          rem;
      logic [QUO_WIDTH-1:0] quo;
      logic                 neg;
      logic                 ovf;
   } lane_type;

   typedef struct packed {
      logic [31:0] cam_x;
      logic [31:0] cam_y;
      logic [31:0] cam_z;
      logic [31:0] zmag;
      logic        zero;
      logic        behind;
      logic        sat;
      lane_type    lx;
      lane_type    ly;
   } div_type;

endpackage

[hdl/camera_view_pinhole_project_top.sv]
// ----------------------------------------------------------------------------
// camera_view_pinhole_project_top
// View transform of world points into camera space with pinhole projection.
// ----------------------------------------------------------------------------
// Usage: a world point enters on the req_ channel as a transaction when
// req_valid is high and req_stall is low. Each point gives exactly one
// transaction on the rsp_ channel with the camera coordinates, the two
// projected coordinates and the depth and clamp flags.
// A point passes five front stages (offset, basis multiply, dot sum,
// numerator multiply, divider setup), 33 restoring divider steps of one
// quotient bit each, and the output register on its way to rsp_valid.
// Throughput is one point per cycle while rsp_stall is low; the divider
// steps are the pipeline depth, not a shared unit.
// The camera registers are written through the csr_ port, one register per
// cycle with csr_write; the user must write them only while no transaction
// is in flight, which the block itself does not enforce. Reset clears every
// valid bit and loads the identity basis, a camera at the origin and unit
// focal length. When the receiver raises rsp_stall, the pipeline fills its
// empty stages and then raises req_stall; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module camera_view_pinhole_project_top #(
   parameter int COORD_WIDTH = cvpp_pkg::COORD_WIDTH_DEFAULT
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     csr_write,
   input  logic [cvpp_pkg::CSR_INDEX_WIDTH-1:0]     csr_index,
   input  logic [cvpp_pkg::CSR_DATA_WIDTH-1:0]      csr_data,
   input  logic                                     req_valid,
   output logic                                     req_stall,
   input  logic signed [COORD_WIDTH-1:0]            req_point_x,
   input  logic signed [COORD_WIDTH-1:0]            req_point_y,
   input  logic signed [COORD_WIDTH-1:0]            req_point_z,
   output logic                                     rsp_valid,
   input  logic                                     rsp_stall,
   output logic signed [31:0]                       rsp_cam_x,
   output logic signed [31:0]                       rsp_cam_y,
   output logic signed [31:0]                       rsp_cam_z,
   output logic signed [31:0]                       rsp_proj_x,
   output logic signed [31:0]                       rsp_proj_y,
   output logic                                     rsp_not_projectable,
   output logic                                     rsp_behind_camera,
   output logic                                     rsp_saturated
);

   localparam int NS = cvpp_pkg::DIV_STAGES;

   // Camera registers. Writes to indexes beyond the list are dropped.
   cvpp_pkg::cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.basis_right     <= cvpp_pkg::RESET_BASIS_RIGHT;
         cfg_ff.basis_up        <= cvpp_pkg::RESET_BASIS_UP;
         cfg_ff.basis_forward   <= cvpp_pkg::RESET_BASIS_FORWARD;
         cfg_ff.camera_position <= cvpp_pkg::RESET_CAMERA_POS;
         cfg_ff.focal_length    <= cvpp_pkg::RESET_FOCAL_LENGTH;
      end else if (csr_write) begin
         unique case (csr_index)
            cvpp_pkg::REG_BASIS_RIGHT:   cfg_ff.basis_right     <= csr_data;
            cvpp_pkg::REG_BASIS_UP:      cfg_ff.basis_up        <= csr_data;
            cvpp_pkg::REG_BASIS_FORWARD: cfg_ff.basis_forward   <= csr_data;
            cvpp_pkg::REG_CAMERA_POS:    cfg_ff.camera_position <= csr_data;
            cvpp_pkg::REG_FOCAL_LENGTH:  cfg_ff.focal_length    <= csr_data[15:0];
            default: begin
            end
         endcase
      end
   end

   // Stage links: entry 0 is the front end output, entry NS the divider
   // output that feeds the response register.
   logic              lv [NS+1];
   logic              lr [NS+1];
   cvpp_pkg::div_type ld [NS+1];
   logic              req_ready;

   cvpp_xform #(
      .COORD_WIDTH(COORD_WIDTH)
   ) u_xform (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_x      (req_point_x),
      .in_y      (req_point_y),
      .in_z      (req_point_z),
      .out_valid (lv[0]),
      .out_ready (lr[0]),
      .out_data  (ld[0])
   );

   assign req_stall = !req_ready;

   // Stage k resolves quotient bit 32 - k, most significant first.
   for (genvar k = 0; k < NS; k++) begin : g_div
      cvpp_div_step #(
         .BIT(NS - 1 - k)
      ) u_step (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (lv[k]),
         .in_ready  (lr[k]),
         .in_data   (ld[k]),
         .out_valid (lv[k+1]),
         .out_ready (lr[k+1]),
         .out_data  (ld[k+1])
      );
   end

   cvpp_out u_out (
      .clock           (clock),
      .reset           (reset),
      .in_valid        (lv[NS]),
      .in_ready        (lr[NS]),
      .in_data         (ld[NS]),
      .out_valid       (rsp_valid),
      .out_stall       (rsp_stall),
      .cam_x           (rsp_cam_x),
      .cam_y           (rsp_cam_y),
      .cam_z           (rsp_cam_z),
      .proj_x          (rsp_proj_x),
      .proj_y          (rsp_proj_y),
      .not_projectable (rsp_not_projectable),
      .behind_camera   (rsp_behind_camera),
      .saturated       (rsp_saturated)
   );

`ifndef ASSERT_OFF
   // A point at zero depth never carries a projected value.
   a_zero_depth_proj: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_not_projectable |-> rsp_proj_x == 0 && rsp_proj_y == 0)
      else $error("projection nonzero at zero depth");

   // The zero depth flag agrees with the delivered depth.
   a_zero_depth_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_not_projectable == (rsp_cam_z == 0))
      else $error("zero depth flag disagrees with depth");

   // The behind flag is the sign of the delivered depth.
   a_behind_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_behind_camera == rsp_cam_z[31])
      else $error("behind flag disagrees with depth sign");

   // Reset leaves no transaction in flight at the output.
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");
`endif

endmodule

[hdl/cvpp_xform.sv]
// ----------------------------------------------------------------------------
// cvpp_xform
// Front stages: offset, basis products, dot sums, numerators, divider setup.
// ----------------------------------------------------------------------------
module cvpp_xform #(
   parameter int COORD_WIDTH = cvpp_pkg::COORD_WIDTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  cvpp_pkg::cfg_type             cfg,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic signed [COORD_WIDTH-1:0] in_x,
   input  logic signed [COORD_WIDTH-1:0] in_y,
   input  logic signed [COORD_WIDTH-1:0] in_z,
   output logic                          out_valid,
   input  logic                          out_ready,
   output cvpp_pkg::div_type             out_data
);

   localparam int DW  = ((COORD_WIDTH > 16) ? COORD_WIDTH : 16) + 1;
   localparam int PW  = DW + 16;
   localparam int SW  = PW + 2;
   localparam int FW  = SW - 6;
   localparam int EW  = (FW > 33) ? FW : 33;
   localparam int NPW = 49;
   localparam logic signed [EW-1:0] MAXV = EW'(64'sh0000_0000_7FFF_FFFF);
   localparam logic signed [EW-1:0] MINV = EW'(-64'sh0000_0000_8000_0000);

   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic r2, r3, r4, r5;

   assign r5 = !v5_ff || out_ready;
   assign r4 = !v4_ff || r5;
   assign r3 = !v3_ff || r4;
   assign r2 = !v2_ff || r3;
   assign in_ready = !v1_ff || r2;

   // Stage 1: offset from the camera center.
   logic signed [DW-1:0] d_ff [3];
   logic signed [DW-1:0] d_in [3];
   always_comb begin
      d_in[0] = DW'(in_x) - DW'($signed(cfg.camera_position[15:0]));
      d_in[1] = DW'(in_y) - DW'($signed(cfg.camera_position[31:16]));
      d_in[2] = DW'(in_z) - DW'($signed(cfg.camera_position[47:32]));
   end

   // Stage 2: nine basis products.
   logic signed [PW-1:0] p_ff [3][3];
   logic signed [PW-1:0] p_in [3][3];
   logic [47:0] basis [3];
   always_comb begin
      basis[0] = cfg.basis_right;
      basis[1] = cfg.basis_up;
      basis[2] = cfg.basis_forward;
      for (int j = 0; j < 3; j++) begin
         for (int k = 0; k < 3; k++) begin
            p_in[j][k] = PW'($signed(basis[j][16*k +: 16])) * PW'(d_ff[k]);
         end
      end
   end

   // Stage 3: dot sums, floor to Q16.16, clamp.
   logic [31:0] c_ff [3];
   logic [31:0] c_in [3];
   logic        csat_ff, csat_in;
   always_comb begin
      logic signed [SW-1:0] s;
      logic signed [FW-1:0] fl;
      logic signed [EW-1:0] e;
      csat_in = 1'b0;
      for (int j = 0; j < 3; j++) begin
         s  = SW'(p_ff[j][0]) + SW'(p_ff[j][1]) + SW'(p_ff[j][2]);
         fl = s[SW-1:6];
         e  = EW'(fl);
         if (e > MAXV) begin
            c_in[j] = 32'h7FFF_FFFF;
            csat_in = 1'b1;
         end else if (e < MINV) begin
            c_in[j] = 32'h8000_0000;
            csat_in = 1'b1;
         end else begin
            c_in[j] = e[31:0];
         end
      end
   end

   // Stage 4: numerators f * cam and depth magnitude.
   logic signed [NPW-1:0] nx_ff, ny_ff, nx_in, ny_in;
   logic [31:0] zm_ff, zm_in;
   logic [31:0] c4_ff [3];
   logic        csat4_ff;
   always_comb begin
      nx_in = NPW'($signed({1'b0, cfg.focal_length})) * NPW'($signed(c_ff[0]));
      ny_in = NPW'($signed({1'b0, cfg.focal_length})) * NPW'($signed(c_ff[1]));
      zm_in = c_ff[2][31] ? (~c_ff[2] + 32'd1) : c_ff[2];
   end

   // Stage 5: dividend magnitudes, signs and overflow test.
   cvpp_pkg::div_type o_ff, o_in;
   function automatic cvpp_pkg::lane_type setup(logic signed [NPW-1:0] n,
                                                logic [31:0] z, logic zneg);
      cvpp_pkg::lane_type l;
      logic [NPW-1:0] m;
      m     = n[NPW-1] ? (~n + NPW'(1)) : n;
      l.nlo = {m[24:0], 8'd0};
      l.ovf = ({8'd0, m[NPW-1:25]} >= z);
      l.rem = l.ovf ? 32'd0 : {8'd0, m[NPW-1:25]};
      l.quo = '0;
      l.neg = n[NPW-1] ^ zneg;
      return l;
   endfunction

   always_comb begin
      o_in.cam_x  = c4_ff[0];
      o_in.cam_y  = c4_ff[1];
      o_in.cam_z  = c4_ff[2];
      o_in.zmag   = zm_ff;
      o_in.zero   = (c4_ff[2] == 32'd0);
      o_in.behind = c4_ff[2][31];
      o_in.sat    = csat4_ff;
      o_in.lx     = setup(nx_ff, zm_ff, c4_ff[2][31]);
      o_in.ly     = setup(ny_ff, zm_ff, c4_ff[2][31]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         if (in_ready) v1_ff <= in_valid;
         if (r2) v2_ff <= v1_ff;
         if (r3) v3_ff <= v2_ff;
         if (r4) v4_ff <= v3_ff;
         if (r5) v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) d_ff <= d_in;
      if (r2) p_ff <= p_in;
      if (r3) begin
         c_ff    <= c_in;
         csat_ff <= csat_in;
      end
      if (r4) begin
         nx_ff    <= nx_in;
         ny_ff    <= ny_in;
         zm_ff    <= zm_in;
         c4_ff    <= c_ff;
         csat4_ff <= csat_ff;
      end
      if (r5) o_ff <= o_in;
   end

   assign out_valid = v5_ff;
   assign out_data  = o_ff;

endmodule

[hdl/cvpp_div_step.sv]
// ----------------------------------------------------------------------------
// cvpp_div_step
// One restoring division step for both projection lanes.
// ----------------------------------------------------------------------------
module cvpp_div_step #(
   parameter int BIT = 0
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  cvpp_pkg::div_type in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output cvpp_pkg::div_type out_data
);

   logic              v_ff;
   cvpp_pkg::div_type d_ff, d_in;

   function automatic cvpp_pkg::lane_type step(cvpp_pkg::lane_type l, logic [31:0] z);
      cvpp_pkg::lane_type r;
      logic [32:0] t;
      r = l;
      t = {l.rem, l.nlo[BIT]};
      if (t >= {1'b0, z}) begin
         t          = t - {1'b0, z};
         r.quo[BIT] = 1'b1;
      end
      r.rem = t[31:0];
      return r;
   endfunction

   always_comb begin
      d_in    = in_data;
      d_in.lx = step(in_data.lx, in_data.zmag);
      d_in.ly = step(in_data.ly, in_data.zmag);
   end

   assign in_ready = !v_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (in_ready) begin
         v_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) d_ff <= d_in;
   end

   assign out_valid = v_ff;
   assign out_data  = d_ff;

endmodule

[hdl/cvpp_out.sv]
// ----------------------------------------------------------------------------
// cvpp_out
// Quotient sign, clamping, zero depth handling and the response register.
// ----------------------------------------------------------------------------
module cvpp_out (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  cvpp_pkg::div_type in_data,
   output logic              out_valid,
   input  logic              out_stall,
   output logic [31:0]       cam_x,
   output logic [31:0]       cam_y,
   output logic [31:0]       cam_z,
   output logic [31:0]       proj_x,
   output logic [31:0]       proj_y,
   output logic              not_projectable,
   output logic              behind_camera,
   output logic              saturated
);

   logic        v_ff;
   logic [31:0] cx_ff, cy_ff, cz_ff, px_ff, py_ff;
   logic        np_ff, bh_ff, sat_ff;
   logic [31:0] px_in, py_in;
   logic        sat_in;

   function automatic logic [32:0] finish(cvpp_pkg::lane_type l);
      logic [32:0] q;
      logic [32:0] r;
      q = l.quo;
      if (l.ovf) begin
         r = l.neg ? {1'b1, 32'h8000_0000} : {1'b1, 32'h7FFF_FFFF};
      end else if (l.neg) begin
         if (q > 33'h0_8000_0000) r = {1'b1, 32'h8000_0000};
         else                     r = {1'b0, 32'(~q + 33'd1)};
      end else begin
         if (q >= 33'h0_8000_0000) r = {1'b1, 32'h7FFF_FFFF};
         else                      r = {1'b0, q[31:0]};
      end
      return r;
   endfunction

   always_comb begin
      logic [32:0] fx, fy;
      fx = finish(in_data.lx);
      fy = finish(in_data.ly);
      if (in_data.zero) begin
         px_in  = 32'd0;
         py_in  = 32'd0;
         sat_in = in_data.sat;
      end else begin
         px_in  = fx[31:0];
         py_in  = fy[31:0];
         sat_in = in_data.sat | fx[32] | fy[32];
      end
   end

   assign in_ready = !v_ff || !out_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (in_ready) begin
         v_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         cx_ff  <= in_data.cam_x;
         cy_ff  <= in_data.cam_y;
         cz_ff  <= in_data.cam_z;
         px_ff  <= px_in;
         py_ff  <= py_in;
         np_ff  <= in_data.zero;
         bh_ff  <= in_data.behind;
         sat_ff <= sat_in;
      end
   end

   assign out_valid       = v_ff;
   assign cam_x           = cx_ff;
   assign cam_y           = cy_ff;
   assign cam_z           = cz_ff;
   assign proj_x          = px_ff;
   assign proj_y          = py_ff;
   assign not_projectable = np_ff;
   assign behind_camera   = bh_ff;
   assign saturated       = sat_ff;

endmodule

[test/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the camera view transform and pinhole projection.
// ----------------------------------------------------------------------------
// Points are queued by a stimulus process and offered by a clocked driver.
// A clocked monitor checks every response against a local model of the view
// transform and projection. The model works from its own copy of the camera
// registers. The run steps through several camera settings, the extremes
// among them, with random idle gaps on both channels.
// ----------------------------------------------------------------------------
module tb;

   // Index with no register behind it; a write there must change nothing.
   localparam logic [cvpp_pkg::CSR_INDEX_WIDTH-1:0] REG_UNUSED = 3'd5;
   localparam int DRAIN_CYCLES = 50;
   localparam int CYCLE_LIMIT  = 600000;
   localparam int LONG_HOLD    = 300;

   typedef struct {
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic signed [15:0] z;
      int                 gap;
   } point_type;

   typedef struct {
      logic signed [31:0] cam_x;
      logic signed [31:0] cam_y;
      logic signed [31:0] cam_z;
      logic signed [31:0] proj_x;
      logic signed [31:0] proj_y;
      logic               not_projectable;
      logic               behind_camera;
      logic               saturated;
   } view_type;

   logic        clock;
   logic        reset;
   logic        csr_write;
   logic [cvpp_pkg::CSR_INDEX_WIDTH-1:0] csr_index;
   logic [cvpp_pkg::CSR_DATA_WIDTH-1:0]  csr_data;
   logic        req_valid;
   logic        req_stall;
   logic signed [15:0] req_point_x;
   logic signed [15:0] req_point_y;
   logic signed [15:0] req_point_z;
   logic        rsp_valid;
   logic        rsp_stall;
   logic signed [31:0] rsp_cam_x;
   logic signed [31:0] rsp_cam_y;
   logic signed [31:0] rsp_cam_z;
   logic signed [31:0] rsp_proj_x;
   logic signed [31:0] rsp_proj_y;
   logic        rsp_not_projectable;
   logic        rsp_behind_camera;
   logic        rsp_saturated;

   // The bench's own copy of the camera registers.
   logic [47:0] basis_u;
   logic [47:0] basis_v;
   logic [47:0] basis_w;
   logic [47:0] cam_pos;
   logic [15:0] focal;

   point_type points_to_send[$];
   view_type  expected_views[$];
   int     errors;
   int     cycles;
   int     send_wait;
   int     recv_wait;
   int     long_left;
   logic   gap_on;
   logic   stall_on;
   logic   hold_go;

   camera_view_pinhole_project_top dut (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Dot product of one packed Q2.14 basis vector with the offset, brought
   // from 22 fraction bits to 16 by an arithmetic shift, which floors.
   function automatic longint basis_dot(logic [47:0] b, longint d0, longint d1,
                                        longint d2);
      longint s;
      s = longint'($signed(b[15:0])) * d0 + longint'($signed(b[31:16])) * d1
        + longint'($signed(b[47:32])) * d2;
      return s >>> 6;
   endfunction

   function automatic longint clamp32(longint v, ref logic sat);
      if (v > 64'sd2147483647) begin
         sat = 1'b1;
         return 64'sd2147483647;
      end
      if (v < -64'sd2147483648) begin
         sat = 1'b1;
         return -64'sd2147483648;
      end
      return v;
   endfunction

   function automatic view_type project_point(point_type p);
      view_type r;
      longint d0, d1, d2, xc, yc, zc, f;
      logic   sat;
      sat = 1'b0;
      d0 = longint'(p.x) - longint'($signed(cam_pos[15:0]));
      d1 = longint'(p.y) - longint'($signed(cam_pos[31:16]));
      d2 = longint'(p.z) - longint'($signed(cam_pos[47:32]));
      xc = clamp32(basis_dot(basis_u, d0, d1, d2), sat);
      yc = clamp32(basis_dot(basis_v, d0, d1, d2), sat);
      zc = clamp32(basis_dot(basis_w, d0, d1, d2), sat);
      f  = longint'({48'd0, focal});
      r.proj_x = '0;
      r.proj_y = '0;
      // Zero depth skips the division entirely; SV division truncates
      // toward zero as the block's divider does.
      if (zc != 0) begin
         r.proj_x = 32'(clamp32((f * xc * 256) / zc, sat));
         r.proj_y = 32'(clamp32((f * yc * 256) / zc, sat));
      end
      r.cam_x = 32'(xc);
      r.cam_y = 32'(yc);
      r.cam_z = 32'(zc);
      r.not_projectable = (zc == 0);
      r.behind_camera = (zc < 0);
      r.saturated = sat;
      return r;
   endfunction

   // Driver: each point waits out its own gap once the channel is free.
   // The expected view is computed at the edge where the point is taken.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_wait <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            point_type taken;
            taken.x = req_point_x;
            taken.y = req_point_y;
            taken.z = req_point_z;
            taken.gap = 0;
            expected_views.push_back(project_point(taken));
         end
         if (!(req_valid && req_stall)) begin
            if (points_to_send.size() == 0) begin
               req_valid <= 1'b0;
            end else if (send_wait < points_to_send[0].gap) begin
               send_wait <= send_wait + 1;
               req_valid <= 1'b0;
            end else begin
               point_type nxt;
               nxt = points_to_send.pop_front();
               req_point_x <= nxt.x;
               req_point_y <= nxt.y;
               req_point_z <= nxt.z;
               req_valid   <= 1'b1;
               send_wait   <= 0;
            end
         end
      end
   end

   // Monitor: checks each accepted transaction against the oldest
   // expectation, then draws the stall for the next one.
   always @(posedge clock) begin
      int nw;
      int nl;
      nw = recv_wait;
      nl = long_left;
      if (reset) begin
         rsp_stall <= 1'b0;
         recv_wait <= 0;
         long_left <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_views.size() == 0) begin
               $display("%0t: response with nothing expected: cam %h %h %h", $realtime,
                        rsp_cam_x, rsp_cam_y, rsp_cam_z);
               errors++;
            end else begin
               view_type e;
               e = expected_views.pop_front();
               if (rsp_cam_x !== e.cam_x) begin
                  $display("%0t: cam_x expected %h actual %h", $realtime, e.cam_x, rsp_cam_x);
                  errors++;
               end
               if (rsp_cam_y !== e.cam_y) begin
                  $display("%0t: cam_y expected %h actual %h", $realtime, e.cam_y, rsp_cam_y);
                  errors++;
               end
               if (rsp_cam_z !== e.cam_z) begin
                  $display("%0t: cam_z expected %h actual %h", $realtime, e.cam_z, rsp_cam_z);
                  errors++;
               end
               if (rsp_proj_x !== e.proj_x) begin
                  $display("%0t: proj_x expected %h actual %h", $realtime, e.proj_x,
                           rsp_proj_x);
                  errors++;
               end
               if (rsp_proj_y !== e.proj_y) begin
                  $display("%0t: proj_y expected %h actual %h", $realtime, e.proj_y,
                           rsp_proj_y);
                  errors++;
               end
               if (rsp_not_projectable !== e.not_projectable) begin
                  $display("%0t: not_projectable expected %b actual %b", $realtime,
                           e.not_projectable, rsp_not_projectable);
                  errors++;
               end
               if (rsp_behind_camera !== e.behind_camera) begin
                  $display("%0t: behind_camera expected %b actual %b", $realtime,
                           e.behind_camera, rsp_behind_camera);
                  errors++;
               end
               if (rsp_saturated !== e.saturated) begin
                  $display("%0t: saturated expected %b actual %b", $realtime,
                           e.saturated, rsp_saturated);
                  errors++;
               end
            end
            nw = stall_on ? $urandom_range(0, 11) : 0;
         end
         // A long hold is counted here, apart from the per-response stalls.
         if (hold_go && nl == 0) nl = LONG_HOLD;
         if (nl > 0) nl--;
         if (nw > 0) nw--;
         rsp_stall <= (nl > 0) || (nw > 0);
         recv_wait <= nw;
         long_left <= nl;
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("tb NOT OK");
         $finish;
      end
   end

   // Registers are written only while nothing is in flight.
   task automatic write_csr(logic [cvpp_pkg::CSR_INDEX_WIDTH-1:0] idx, logic [47:0] val);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      case (idx)
         cvpp_pkg::REG_BASIS_RIGHT:   basis_u = val;
         cvpp_pkg::REG_BASIS_UP:      basis_v = val;
         cvpp_pkg::REG_BASIS_FORWARD: basis_w = val;
         cvpp_pkg::REG_CAMERA_POS:    cam_pos = val;
         cvpp_pkg::REG_FOCAL_LENGTH:  focal   = val[15:0];
         default: ;
      endcase
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic write_camera(logic [47:0] u, logic [47:0] v, logic [47:0] w,
                               logic [47:0] c, logic [47:0] f);
      write_csr(cvpp_pkg::REG_BASIS_RIGHT, u);
      write_csr(cvpp_pkg::REG_BASIS_UP, v);
      write_csr(cvpp_pkg::REG_BASIS_FORWARD, w);
      write_csr(cvpp_pkg::REG_CAMERA_POS, c);
      write_csr(cvpp_pkg::REG_FOCAL_LENGTH, f);
   endtask

   // Waits until the last response is in and the pipeline has emptied.
   task automatic wait_idle();
      do @(posedge clock);
      while (points_to_send.size() != 0 || expected_views.size() != 0 || req_valid);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic queue_point(logic [15:0] x, logic [15:0] y, logic [15:0] z);
      point_type p;
      p.x = x;
      p.y = y;
      p.z = z;
      p.gap = gap_on ? $urandom_range(0, 11) : 0;
      points_to_send.push_back(p);
   endtask

   function automatic logic [15:0] edge_value();
      case ($urandom_range(0, 3))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'h0000;
         default: return 16'hFFFF;
      endcase
   endfunction

   // Random points: mostly free, some close to the camera so that the depth
   // lands on zero or flips sign, some on the field extremes.
   task automatic queue_random(int count);
      for (int i = 0; i < count; i++) begin
         int k;
         k = $urandom_range(0, 9);
         if (k <= 5) begin
            queue_point(16'($urandom), 16'($urandom), 16'($urandom));
         end else if (k <= 7) begin
            queue_point(cam_pos[15:0] + 16'($urandom_range(0, 8) - 4),
                        cam_pos[31:16] + 16'($urandom_range(0, 8) - 4),
                        cam_pos[47:32] + 16'($urandom_range(0, 8) - 4));
         end else if (k == 8) begin
            queue_point(cam_pos[15:0], cam_pos[31:16], cam_pos[47:32]);
         end else begin
            queue_point(edge_value(), edge_value(), edge_value());
         end
      end
   endtask

   function automatic logic [47:0] rand48();
      return 48'({$urandom, $urandom});
   endfunction

   initial begin
      reset = 1'b1;
      csr_write = 1'b0;
      csr_index = '0;
      csr_data = '0;
      req_valid = 1'b0;
      req_point_x = '0;
      req_point_y = '0;
      req_point_z = '0;
      rsp_stall = 1'b0;
      errors = 0;
      cycles = 0;
      gap_on = 1'b0;
      stall_on = 1'b0;
      hold_go = 1'b0;
      basis_u = cvpp_pkg::RESET_BASIS_RIGHT;
      basis_v = cvpp_pkg::RESET_BASIS_UP;
      basis_w = cvpp_pkg::RESET_BASIS_FORWARD;
      cam_pos = cvpp_pkg::RESET_CAMERA_POS;
      focal = cvpp_pkg::RESET_FOCAL_LENGTH;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed points under the reset camera: extremes, the origin (zero
      // depth), behind the camera, and a sign mix.
      queue_point(16'h0000, 16'h0000, 16'h0000);
      queue_point(16'h7FFF, 16'h7FFF, 16'h7FFF);
      queue_point(16'h8000, 16'h8000, 16'h8000);
      queue_point(16'h7FFF, 16'h8000, 16'h0001);
      queue_point(16'h8000, 16'h7FFF, 16'hFFFF);
      queue_point(16'h0100, 16'hFF00, 16'hFE00);
      queue_point(16'h1234, 16'h5678, 16'h0000);
      wait_idle();

      // Largest focal length with a shallow depth drives both projections
      // into the clamp; a write to an unused index must change nothing.
      write_csr(cvpp_pkg::REG_FOCAL_LENGTH, 48'hABCD_1234_FFFF);
      write_csr(REG_UNUSED, rand48());
      queue_point(16'h7FFF, 16'h8000, 16'h0001);
      queue_point(16'h8000, 16'h7FFF, 16'hFFFF);
      queue_point(16'h7FFF, 16'h7FFF, 16'h0100);
      queue_point(16'h0001, 16'hFFFF, 16'h7FFF);
      wait_idle();

      // Extreme camera: all basis components at the positive and negative
      // limits, camera at the opposite corner, and a zero focal length.
      write_camera(48'h7FFF_7FFF_7FFF, 48'h8000_8000_8000, 48'h7FFF_8000_7FFF,
                   48'h8000_8000_8000, 48'h0);
      queue_point(16'h7FFF, 16'h7FFF, 16'h7FFF);
      queue_point(16'h8000, 16'h8000, 16'h8000);
      queue_point(16'h7FFF, 16'h8000, 16'h7FFF);
      gap_on = 1'b1;
      stall_on = 1'b1;
      queue_random(150);
      wait_idle();

      write_camera(48'h8000_8000_8000, 48'h7FFF_7FFF_7FFF, 48'h8000_8000_8000,
                   48'h7FFF_7FFF_7FFF, 48'hFFFF);
      queue_random(150);
      wait_idle();

      // Back-to-back points while the receiver holds off for a long time:
      // the pipeline fills and must stall its input.
      write_camera(cvpp_pkg::RESET_BASIS_RIGHT, cvpp_pkg::RESET_BASIS_UP,
                   cvpp_pkg::RESET_BASIS_FORWARD, 48'h0010_FFF0_0000, 48'h0200);
      gap_on = 1'b0;
      stall_on = 1'b0;
      hold_go <= 1'b1;
      @(posedge clock);
      hold_go <= 1'b0;
      queue_random(200);
      wait_idle();

      for (int phase = 0; phase < 4; phase++) begin
         write_camera(rand48(), rand48(), rand48(), rand48(), rand48());
         gap_on = phase[0];
         stall_on = phase[1];
         queue_random(200);
         wait_idle();
      end

      if (errors == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end

endmodule
